// File: hdl/assert_macros.svh
// Assertion macros for the keyed ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KRB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define KRB_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define KRB_ASSERT(label, clk, rst_n, prop)
`define KRB_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: hdl/krb_pkg.sv
// ----------------------------------------------------------------------------
// krb_pkg
// Shared types and constants of the keyed ring byte buffer.
// ----------------------------------------------------------------------------
`default_nettype none
package krb_pkg;
  localparam int unsigned DefSlots     = 5;
  localparam int unsigned DefRingDepth = 1024;
  localparam int unsigned KeyW         = 16;
  localparam int unsigned ByteW        = 8;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOSLOT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [KeyW-1:0]  socket_id;
    logic [ByteW-1:0] data_in;
    logic             end_of_call;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ByteW-1:0] data_out;
    logic             last_of_call;
  } out_item_t;
endpackage
`default_nettype wire

// File: hdl/krb_in_if.sv
// ----------------------------------------------------------------------------
// krb_in_if
// Valid/ready channel for request items.
// ----------------------------------------------------------------------------
`default_nettype none
interface krb_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [15:0]      socket_id;
  logic [7:0]       data_in;
  logic             end_of_call;
  modport source (output valid, action, socket_id, data_in, end_of_call, input ready);
  modport sink   (input valid, action, socket_id, data_in, end_of_call, output ready);
endinterface
`default_nettype wire

// File: hdl/krb_out_if.sv
// ----------------------------------------------------------------------------
// krb_out_if
// Valid/ready channel for result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface krb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  logic       last_of_call;
  modport source (output valid, status, data_out, last_of_call, input ready);
  modport sink   (input valid, status, data_out, last_of_call, output ready);
endinterface
`default_nettype wire

// File: hdl/keyed_multi_ring_byte_buffer.sv
// ----------------------------------------------------------------------------
// keyed_multi_ring_byte_buffer
// Keyed table of byte rings with write, read and delete actions.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries request items: action, socket_id, data_in, end_of_call.
//   out_if carries exactly one result item per request: status, data_out,
//   last_of_call, in request order.
//   A front queue of two entries takes requests; the back end matches the
//   key against all slots in parallel and updates the pointers as it takes it.
//   Each result is registered in the back end after the front queue; a read
//   that fetches a byte also waits for the registered memory read.
//   Throughput: 1 item per cycle without reads while the receiver is ready;
//   a byte read holds off the next item until the ring memory byte lands.
//   Reset clears all slots (valid, key, pointers, counts) at once; the ring
//   memory is not cleared and need not be, as only written bytes are read.
//   When the receiver stalls, the result holds, the back end stops and the
//   front queue fills and then drops ready.
// ----------------------------------------------------------------------------
`default_nettype none
module keyed_multi_ring_byte_buffer #(
  parameter int unsigned Slots     = krb_pkg::DefSlots,
  parameter int unsigned RingDepth = krb_pkg::DefRingDepth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  krb_in_if.sink   in_if,
  krb_out_if.source out_if
);
  import krb_pkg::*;

  in_item_t  in_item, q_item;
  out_item_t out_item;
  logic      q_valid, q_pop;

  assign in_item.action      = in_if.action;
  assign in_item.socket_id   = in_if.socket_id;
  assign in_item.data_in     = in_if.data_in;
  assign in_item.end_of_call = in_if.end_of_call;

  krb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_ready_o (in_if.ready), .in_item_i (in_item),
    .q_valid_o (q_valid), .q_pop_i (q_pop), .q_item_o (q_item)
  );

  krb_back #(.Slots(Slots), .RingDepth(RingDepth)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid), .q_pop_o (q_pop), .q_item_i (q_item),
    .out_valid_o (out_if.valid), .out_ready_i (out_if.ready), .out_item_o (out_item)
  );

  assign out_if.status       = out_item.status;
  assign out_if.data_out     = out_item.data_out;
  assign out_if.last_of_call = out_item.last_of_call;
endmodule
`default_nettype wire

// File: hdl/krb_front.sv
// ----------------------------------------------------------------------------
// krb_front
// Accepts request items into a two-entry queue ahead of the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module krb_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire krb_pkg::in_item_t in_item_i,
  output logic                   q_valid_o,
  input  wire logic              q_pop_i,
  output krb_pkg::in_item_t      q_item_o
);
  import krb_pkg::*;

  in_item_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// File: hdl/krb_back.sv
// ----------------------------------------------------------------------------
// krb_back
// Slot table, key match, ring memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module krb_back #(
  parameter int unsigned Slots     = krb_pkg::DefSlots,
  parameter int unsigned RingDepth = krb_pkg::DefRingDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  output logic                    q_pop_o,
  input  wire krb_pkg::in_item_t  q_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output krb_pkg::out_item_t      out_item_o
);
  import krb_pkg::*;

  localparam int unsigned SW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned PW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int unsigned CW = $clog2(RingDepth + 1);
  localparam int unsigned AW = $clog2(Slots * RingDepth);
  localparam logic [CW-1:0] FullCnt = CW'(RingDepth);
  localparam logic [PW-1:0] LastPtr = PW'(RingDepth - 1);

  logic [Slots-1:0]  valid_q;
  logic [KeyW-1:0]   key_q  [Slots];
  logic [PW-1:0]     rptr_q [Slots];
  logic [PW-1:0]     wptr_q [Slots];
  logic [CW-1:0]     cnt_q  [Slots];
  logic [ByteW-1:0]  ring_mem [Slots*RingDepth];

  // Output register, plus a pending flag for the registered memory read.
  logic              ov_q;
  out_item_t         oi_q;
  logic              rd_pend_q;

  logic              hit, freef, go;
  logic [SW-1:0]     hs, fs, s;
  logic              have;
  logic [1:0]        st;
  logic              do_wr, do_rd;
  logic [AW-1:0]     addr;
  logic [ByteW-1:0]  rd_q;

  always_comb begin
    hit = 1'b0; hs = '0; freef = 1'b0; fs = '0;
    for (int i = Slots-1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == q_item_i.socket_id) begin
        hit = 1'b1; hs = SW'(i);
      end
      if (!valid_q[i]) begin
        freef = 1'b1; fs = SW'(i);
      end
    end
  end

  // Take a new item only when the result register is free or being taken and no read pending.
  assign go = q_valid_i && !rd_pend_q && (!ov_q || out_ready_i);
  assign q_pop_o = go;

  always_comb begin
    s = hs; have = hit; st = ST_NOSLOT; do_wr = 1'b0; do_rd = 1'b0;
    unique case (action_e'(q_item_i.action))
      ACT_WRITE: begin
        if (!hit) begin s = fs; have = freef; end
        if (have) begin
          if (hit && cnt_q[hs] == FullCnt) st = ST_FULL;
          else begin st = ST_OK; do_wr = 1'b1; end
        end
      end
      ACT_READ: begin
        if (hit) begin
          if (cnt_q[hs] == '0) st = ST_EMPTY;
          else begin st = ST_OK; do_rd = 1'b1; end
        end
      end
      ACT_DELETE: if (hit) st = ST_OK;
      default: st = ST_NOSLOT;
    endcase
  end

  assign addr = AW'(s) * AW'(RingDepth)
              + AW'(do_wr ? (hit ? wptr_q[s] : '0) : rptr_q[s]);

  always_ff @(posedge clk_i) begin
    if (go && do_wr) ring_mem[addr] <= q_item_i.data_in;
    if (go && do_rd) rd_q <= ring_mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < Slots; i++) begin
        key_q[i] <= '0; rptr_q[i] <= '0; wptr_q[i] <= '0; cnt_q[i] <= '0;
      end
    end else if (go) begin
      unique case (action_e'(q_item_i.action))
        ACT_WRITE: if (have) begin
          if (!hit) begin
            valid_q[s] <= 1'b1; key_q[s] <= q_item_i.socket_id;
            rptr_q[s] <= '0;
          end
          if (do_wr) begin
            wptr_q[s] <= (hit && wptr_q[s] != LastPtr) ? wptr_q[s] + 1'b1
                       : (!hit && RingDepth > 1) ? PW'(1) : '0;
            cnt_q[s]  <= (hit ? cnt_q[s] : '0) + 1'b1;
          end
        end
        ACT_READ: if (do_rd) begin
          rptr_q[s] <= (rptr_q[s] == LastPtr) ? '0 : rptr_q[s] + 1'b1;
          cnt_q[s]  <= cnt_q[s] - 1'b1;
        end
        ACT_DELETE: if (hit) begin
          valid_q[s] <= 1'b0; key_q[s] <= '0;
          rptr_q[s] <= '0; wptr_q[s] <= '0; cnt_q[s] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= go && do_rd;
      if (go) ov_q <= 1'b1;
      else if (out_ready_i && !rd_pend_q) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      oi_q.status <= st; oi_q.data_out <= '0;
      oi_q.last_of_call <= q_item_i.end_of_call;
    end else if (rd_pend_q) oi_q.data_out <= rd_q;
  end

  // Result is shown once the memory byte has landed.
  assign out_valid_o = ov_q && !rd_pend_q;
  assign out_item_o  = oi_q;

  `KRB_ASSERT(a_pend_has_out, clk_i, rst_ni, rd_pend_q |-> ov_q)
  `KRB_ASSERT(a_no_take_pend, clk_i, rst_ni, rd_pend_q |-> !go)
  `KRB_ASSERT(a_rd_ok, clk_i, rst_ni, (go && do_rd) |=> (oi_q.status == ST_OK))
endmodule
`default_nettype wire

// File: verif/krb_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krb_tb_pkg
// Ring table predictor and result scoreboard for the keyed byte buffer bench.
// ----------------------------------------------------------------------------
package krb_tb_pkg;
  import krb_pkg::*;

  localparam int unsigned NSlots = DefSlots;
  localparam int unsigned Depth  = DefRingDepth;

  class ring_table_scoreboard;
    bit               valid_q [NSlots];
    logic [15:0]      key_q   [NSlots];
    logic [7:0]       store_q [NSlots][Depth];
    int unsigned      rd_q    [NSlots];
    int unsigned      wr_q    [NSlots];
    int unsigned      fill_q  [NSlots];
    out_item_t        pending_q[$];
    int unsigned      errors;

    function new();
      errors = 0;
      for (int i = 0; i < NSlots; i++) begin
        valid_q[i] = 0; key_q[i] = '0; rd_q[i] = 0; wr_q[i] = 0; fill_q[i] = 0;
      end
    endfunction

    function int unsigned fill_of(int unsigned s);
      return fill_q[s];
    endfunction

    // Apply one accepted request and queue the answer it must produce.
    function void note_request(in_item_t it);
      int unsigned s;
      out_item_t   r;
      s = NSlots;
      for (int i = NSlots - 1; i >= 0; i--)
        if (valid_q[i] && key_q[i] == it.socket_id) s = i;
      r.status       = ST_NOSLOT;
      r.data_out     = '0;
      r.last_of_call = it.end_of_call;
      case (action_e'(it.action))
        ACT_WRITE: begin
          if (s == NSlots) begin
            for (int i = NSlots - 1; i >= 0; i--)
              if (!valid_q[i]) s = i;
            if (s < NSlots) begin
              valid_q[s] = 1; key_q[s] = it.socket_id;
              rd_q[s] = 0; wr_q[s] = 0; fill_q[s] = 0;
            end
          end
          if (s < NSlots) begin
            if (fill_q[s] >= Depth) r.status = ST_FULL;
            else begin
              store_q[s][wr_q[s]] = it.data_in;
              wr_q[s] = (wr_q[s] + 1) % Depth;
              fill_q[s]++;
              r.status = ST_OK;
            end
          end
        end
        ACT_READ: begin
          if (s < NSlots) begin
            if (fill_q[s] == 0) r.status = ST_EMPTY;
            else begin
              r.data_out = store_q[s][rd_q[s]];
              rd_q[s] = (rd_q[s] + 1) % Depth;
              fill_q[s]--;
              r.status = ST_OK;
            end
          end
        end
        ACT_DELETE: begin
          if (s < NSlots) begin
            valid_q[s] = 0; key_q[s] = '0;
            rd_q[s] = 0; wr_q[s] = 0; fill_q[s] = 0;
            r.status = ST_OK;
          end
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.data_out !== exp_r.data_out) begin
        $display("%0t: data_out expected %0h actual %0h", $time, exp_r.data_out,
                 got.data_out);
        errors++;
      end
      if (got.last_of_call !== exp_r.last_of_call) begin
        $display("%0t: last_of_call expected %0b actual %0b", $time,
                 exp_r.last_of_call, got.last_of_call);
        errors++;
      end
    endfunction
  endclass
endpackage

// File: verif/keyed_multi_ring_byte_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_multi_ring_byte_buffer_tb
// Drives random and directed write/read/delete requests across a handful of
// keys, predicts every answer with a software ring table and compares each
// result item field by field, with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module keyed_multi_ring_byte_buffer_tb;
  import krb_pkg::*;
  import krb_tb_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  krb_in_if  req_if ();
  krb_out_if rsp_if ();

  keyed_multi_ring_byte_buffer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_if.sink),
    .out_if (rsp_if.source)
  );

  ring_table_scoreboard sb = new();

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int unsigned idle_cycles = 0;
  bit          stall_on    = 1'b0;
  logic [15:0] key_pool [6];

  initial begin
    req_if.valid = 1'b0;
    req_if.action = '0;
    req_if.socket_id = '0;
    req_if.data_in = '0;
    req_if.end_of_call = 1'b0;
    rsp_if.ready = 1'b0;
  end

  // Receiver: stall in runs, with calm stretches where ready stays high.
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_on && ((stall_phase % 97) < 60))
      rsp_if.ready <= ($urandom_range(0, 3) != 0);
    else
      rsp_if.ready <= 1'b1;
  end

  // Check every accepted result; watch for a stuck handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(out_item_t'{rsp_if.status, rsp_if.data_out, rsp_if.last_of_call});
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one request and hold it until accepted.
  task automatic send_item(action_e act, logic [15:0] key, logic [7:0] data, bit eoc);
    in_item_t it;
    it = '{act, key, data, eoc};
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.socket_id   <= key;
    req_if.data_in     <= data;
    req_if.end_of_call <= eoc;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(it);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n == 0) return;
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned pick;
    action_e     act;
    logic [15:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 50)      act = ACT_WRITE;
    else if (pick < 85) act = ACT_READ;
    else if (pick < 97) act = ACT_DELETE;
    else                act = ACT_NONE;
    key = ($urandom_range(0, 19) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 5)];
    send_item(act, key, 8'($urandom), 1'($urandom));
  endtask

  initial begin
    key_pool = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001, 16'h00FF, 16'h7FFE};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: misses on an empty table, key 0 and all-ones, empty read.
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0);
    send_item(ACT_DELETE, 16'hFFFF, 8'hFF, 1'b1);
    send_item(ACT_NONE,   16'h0000, 8'hAA, 1'b1);
    send_item(ACT_WRITE,  16'h0000, 8'h00, 1'b0);
    send_item(ACT_WRITE,  16'hFFFF, 8'hFF, 1'b1);
    send_item(ACT_READ,   16'h0000, 8'h55, 1'b1);
    send_item(ACT_READ,   16'h0000, 8'h00, 1'b0);
    // Fill every slot; the last of these writes and the next find no free slot.
    for (int i = 0; i < 4; i++) send_item(ACT_WRITE, 16'(16'h0100 + i), 8'(i), 1'b0);
    send_item(ACT_WRITE,  16'hBEEF, 8'h11, 1'b1);
    // Delete frees a slot that a new key then reuses.
    send_item(ACT_DELETE, 16'h0101, 8'h00, 1'b0);
    send_item(ACT_WRITE,  16'hBEEF, 8'h22, 1'b0);
    send_item(ACT_READ,   16'hBEEF, 8'h00, 1'b1);
    send_item(ACT_DELETE, 16'h0101, 8'h00, 1'b1);
    // Fill one ring completely, overflow it, wrap the write side, refill.
    for (int i = 0; i < DefRingDepth; i++) send_item(ACT_WRITE, 16'hFFFF, 8'($urandom), 1'($urandom));
    send_item(ACT_WRITE, 16'hFFFF, 8'h77, 1'b0);
    for (int i = 0; i < 10; i++) send_item(ACT_READ, 16'hFFFF, 8'h00, 1'b0);
    for (int i = 0; i < 10; i++) send_item(ACT_WRITE, 16'hFFFF, 8'($urandom), 1'b1);
    send_item(ACT_WRITE, 16'hFFFF, 8'h78, 1'b1);
    for (int i = 0; i < 20; i++) send_item(ACT_READ, 16'hFFFF, 8'h00, 1'($urandom));
    // Clear the table so the random part starts from the key pool.
    for (int i = 0; i < 4; i++) send_item(ACT_DELETE, 16'(16'h0100 + i), 8'h00, 1'b0);
    send_item(ACT_DELETE, 16'h0000, 8'h00, 1'b0);
    send_item(ACT_DELETE, 16'hFFFF, 8'h00, 1'b0);
    send_item(ACT_DELETE, 16'hBEEF, 8'h00, 1'b0);

    // Random bursts with gaps; receiver stalls from here on.
    stall_on = 1'b1;
    for (int n = 0; n < 400; ) begin
      int unsigned burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        random_item();
        n++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    req_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/krb_pkg.sv
hdl/krb_in_if.sv
hdl/krb_out_if.sv
hdl/krb_front.sv
hdl/krb_back.sv
hdl/keyed_multi_ring_byte_buffer.sv
verif/krb_tb_pkg.sv
verif/keyed_multi_ring_byte_buffer_tb.sv
